### src/rawi_pkg.sv
package rawi_pkg;

  // Number of quotient bits; a larger crossing magnitude cannot land in a 16-bit span
  localparam int QBITS = 17;
  localparam int QDEPTH = 4;

  // Job kinds decided by the front end
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_VRAY = 2'd1;
  localparam logic [1:0] KIND_DIV  = 2'd2;
  localparam logic [1:0] KIND_MUL  = 2'd3;

  typedef struct packed {
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic               dir_right;
    logic               dir_up;
    logic               ray_vertical;
    logic signed [31:0] ray_slope;
    logic signed [39:0] ray_intercept;
    logic               wall_vertical;
    logic signed [15:0] wall_ax;
    logic signed [15:0] wall_ay;
    logic signed [15:0] wall_bx;
    logic signed [15:0] wall_by;
  } in_t;

  typedef struct packed {
    logic               hit;
    logic signed [15:0] hit_x;
    logic signed [15:0] hit_y;
    logic               wall_bad;
  } out_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic               bad;
    logic signed [15:0] lo;
    logic signed [15:0] hi;
    logic signed [15:0] wc;
    logic signed [15:0] ox;
    logic signed [31:0] m;
    logic signed [39:0] b;
  } job_t;

  typedef struct packed {
    logic               valid;
    logic [1:0]         kind;
    logic               bad;
    logic signed [15:0] lo;
    logic signed [15:0] hi;
    logic signed [15:0] wc;
    logic signed [15:0] ox;
    logic signed [39:0] b;
    logic               neg;
    logic               ovf;
    logic [31:0]        am;
    logic [39:0]        mag;
    logic signed [47:0] prod;
    logic signed [48:0] ysum;
    logic [32:0]        rem;
    logic [QBITS-1:0]   q;
  } pipe_t;

endpackage

### src/rawi_front.sv
module rawi_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_push,
  output logic            in_full,
  input  rawi_pkg::in_t   in_data,
  output logic            job_valid,
  input  logic            job_ready,
  output rawi_pkg::job_t  job
);
  import rawi_pkg::*;

  logic valid_r, valid_nxt;
  job_t job_r, job_nxt;
  logic take;

  // Accept a beat whenever the stage is empty or drains this cycle
  assign in_full   = valid_r && !job_ready;
  assign take      = in_push && !in_full;
  assign job_valid = valid_r;
  assign job       = job_r;

  // Classify the ray-wall pair
  always_comb begin
    logic ok;
    ok = 1'b0;
    job_nxt.ox = in_data.origin_x;
    job_nxt.m  = in_data.ray_slope;
    job_nxt.b  = in_data.ray_intercept;
    job_nxt.kind = KIND_NONE;
    if (in_data.wall_vertical) begin
      job_nxt.bad = in_data.wall_ax != in_data.wall_bx;
      job_nxt.wc  = in_data.wall_ax;
      job_nxt.lo  = (in_data.wall_ay < in_data.wall_by) ? in_data.wall_ay : in_data.wall_by;
      job_nxt.hi  = (in_data.wall_ay < in_data.wall_by) ? in_data.wall_by : in_data.wall_ay;
      ok = (in_data.wall_ax != in_data.origin_x) &&
           !(in_data.dir_right && in_data.origin_x > in_data.wall_ax) &&
           !(!in_data.dir_right && in_data.origin_x < in_data.wall_ax);
      if (!job_nxt.bad && ok && !in_data.ray_vertical) job_nxt.kind = KIND_MUL;
    end else begin
      job_nxt.bad = in_data.wall_ay != in_data.wall_by;
      job_nxt.wc  = in_data.wall_ay;
      job_nxt.lo  = (in_data.wall_ax < in_data.wall_bx) ? in_data.wall_ax : in_data.wall_bx;
      job_nxt.hi  = (in_data.wall_ax < in_data.wall_bx) ? in_data.wall_bx : in_data.wall_ax;
      ok = (in_data.wall_ay != in_data.origin_y) &&
           !(in_data.dir_up && in_data.origin_y > in_data.wall_ay) &&
           !(!in_data.dir_up && in_data.origin_y < in_data.wall_ay);
      if (!job_nxt.bad && ok) begin
        if (in_data.ray_vertical) job_nxt.kind = KIND_VRAY;
        else if (in_data.ray_slope != 32'sd0) job_nxt.kind = KIND_DIV;
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (job_ready) valid_nxt = 1'b0;
    if (take) valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      job_r <= job_nxt;
    end
  end

endmodule

### src/rawi_queue.sv
module rawi_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  rawi_pkg::job_t  wr_data,
  output logic            rd_valid,
  input  logic            rd_en,
  output rawi_pkg::job_t  rd_data
);
  import rawi_pkg::*;

  localparam int AW = $clog2(QDEPTH);

  job_t mem_r [QDEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic do_wr, do_rd;

  assign wr_ready = cnt_r != (AW+1)'(QDEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_data  = mem_r[rp_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_en && rd_valid;

  // Advance pointers and occupancy
  always_comb begin
    wp_nxt  = do_wr ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_rd ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (AW+1)'(do_wr) - (AW+1)'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

### src/rawi_back.sv
module rawi_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            job_valid,
  output logic            job_take,
  input  rawi_pkg::job_t  job,
  output logic            out_empty,
  input  logic            out_pop,
  output rawi_pkg::out_t  out_data
);
  import rawi_pkg::*;

  localparam int NST = QBITS + 1;

  pipe_t st_r [NST];
  pipe_t st_nxt [NST];
  logic  en;
  logic  out_valid_r;
  out_t  out_r, out_nxt;

  // Whole pipe moves while the output register is free or drains
  assign en        = !out_valid_r || out_pop;
  assign job_take  = en && job_valid;
  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

  // Stage A: numerator magnitude, slope magnitude, product
  always_comb begin
    logic signed [40:0] num;
    num = {{9{job.wc[15]}}, job.wc, 16'b0} - {job.b[39], job.b};
    st_nxt[0]       = '0;
    st_nxt[0].valid = job_valid;
    st_nxt[0].kind  = job.kind;
    st_nxt[0].bad   = job.bad;
    st_nxt[0].lo    = job.lo;
    st_nxt[0].hi    = job.hi;
    st_nxt[0].wc    = job.wc;
    st_nxt[0].ox    = job.ox;
    st_nxt[0].b     = job.b;
    st_nxt[0].neg   = num[40] ^ job.m[31];
    st_nxt[0].mag   = num[40] ? 40'(-num) : num[39:0];
    st_nxt[0].am    = job.m[31] ? 32'(-job.m) : job.m;
    st_nxt[0].prod  = job.m * 48'(job.wc);
  end

  // Stage B: overflow check, seed remainder, y sum
  always_comb begin
    st_nxt[1]      = st_r[0];
    st_nxt[1].ovf  = {9'b0, st_r[0].mag} >= {st_r[0].am, 17'b0};
    st_nxt[1].rem  = {10'b0, st_r[0].mag[39:QBITS]};
    st_nxt[1].q    = '0;
    st_nxt[1].ysum = 49'(st_r[0].prod) + 49'(st_r[0].b);
  end

  // Division stages: one quotient bit each, most significant first
  for (genvar k = 0; k < QBITS; k++) begin : g_div
    if (k < QBITS - 1) begin : g_mid
      always_comb begin
        logic [32:0] t;
        t = {st_r[k+1].rem[31:0], st_r[k+1].mag[QBITS-1-k]};
        st_nxt[k+2] = st_r[k+1];
        if (t >= {1'b0, st_r[k+1].am}) begin
          st_nxt[k+2].rem = t - {1'b0, st_r[k+1].am};
          st_nxt[k+2].q[QBITS-1-k] = 1'b1;
        end else begin
          st_nxt[k+2].rem = t;
        end
      end
    end
  end

  // Last quotient bit, sign, span check and result
  always_comb begin
    logic [32:0] t;
    logic [QBITS-1:0] qf;
    logic signed [QBITS:0] qs;
    logic signed [32:0] ysh, yv;
    pipe_t p;
    p  = st_r[NST-1];
    t  = {p.rem[31:0], p.mag[0]};
    qf = p.q;
    if (t >= {1'b0, p.am}) qf[0] = 1'b1;
    qs  = p.neg ? -$signed({1'b0, qf}) : $signed({1'b0, qf});
    ysh = p.ysum[48:16];
    yv  = (p.ysum[48] && p.ysum[15:0] != 16'd0) ? ysh + 33'sd1 : ysh;
    out_nxt = '0;
    out_nxt.wall_bad = p.bad;
    case (p.kind)
      KIND_VRAY: begin
        if (p.ox >= p.lo && p.ox <= p.hi) begin
          out_nxt.hit = 1'b1;
          out_nxt.hit_x = p.ox;
          out_nxt.hit_y = p.wc;
        end
      end
      KIND_DIV: begin
        if (!p.ovf && qs >= (QBITS+1)'(p.lo) && qs <= (QBITS+1)'(p.hi)) begin
          out_nxt.hit = 1'b1;
          out_nxt.hit_x = qs[15:0];
          out_nxt.hit_y = p.wc;
        end
      end
      KIND_MUL: begin
        if (yv >= 33'(p.lo) && yv <= 33'(p.hi)) begin
          out_nxt.hit = 1'b1;
          out_nxt.hit_x = p.wc;
          out_nxt.hit_y = yv[15:0];
        end
      end
      default: begin
        out_nxt.hit = 1'b0;
      end
    endcase
  end

  // Clear valid bits under reset, advance the whole pipe on enable
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NST; i++) st_r[i].valid <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      for (int i = 0; i < NST; i++) st_r[i] <= st_nxt[i];
      out_valid_r <= st_r[NST-1].valid;
      out_r <= out_nxt;
    end
  end

endmodule

### src/ray_axis_wall_intersect_unit.sv
// Path from the edge that accepts an input beat to its result beat on the ports: front register,
// queue write, two setup stages, sixteen quotient stages, output register with the last bit.
// Throughput: one beat per cycle unless out_pop stalls; the quotient stages set depth, not rate.
// Reset: synchronous, active-low rst_n clears all valid bits, the queue and the output.
module ray_axis_wall_intersect_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_push,
  output logic           in_full,
  input  rawi_pkg::in_t  in_data,
  output logic           out_empty,
  input  logic           out_pop,
  output rawi_pkg::out_t out_data
);
  import rawi_pkg::*;

  logic f_valid, f_ready, q_valid, q_take;
  job_t f_job, q_job;

  rawi_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .job_valid (f_valid),
    .job_ready (f_ready),
    .job       (f_job)
  );

  rawi_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_job),
    .rd_valid (q_valid),
    .rd_en    (q_take),
    .rd_data  (q_job)
  );

  rawi_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_valid),
    .job_take  (q_take),
    .job       (q_job),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

### tb/ray_axis_wall_intersect_unit_tb.sv
module ray_axis_wall_intersect_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rawi_pkg::*;

  // Hit/miss outcomes kept in arrival order against result beats
  class crossing_board;
    out_t pending[$];
    int   errors;

    function new();
      errors = 0;
    endfunction

    // Compute the crossing for one accepted ray/wall beat
    function void note_pair(in_t p);
      out_t r;
      longint ox, oy, m, b, ax, ay, bx, by, lo, hi, x, y, num;
      bit ok, have;
      ox = p.origin_x; oy = p.origin_y;
      m = p.ray_slope; b = p.ray_intercept;
      ax = p.wall_ax; ay = p.wall_ay; bx = p.wall_bx; by = p.wall_by;
      r = '0;
      r.wall_bad = p.wall_vertical ? (ax != bx) : (ay != by);
      if (!r.wall_bad) begin
        if (!p.wall_vertical) begin
          lo = (ax < bx) ? ax : bx;
          hi = (ax < bx) ? bx : ax;
          ok = (ay != oy) && !(p.dir_up && oy > ay) && !(!p.dir_up && oy < ay);
          have = 1'b0;
          x = 0;
          if (ok) begin
            if (p.ray_vertical) begin
              x = ox;
              have = 1'b1;
            end else if (m != 0) begin
              num = ay * 65536 - b;
              x = num / m;
              have = 1'b1;
            end
          end
          if (have && x >= lo && x <= hi) begin
            r.hit = 1'b1;
            r.hit_x = x[15:0];
            r.hit_y = ay[15:0];
          end
        end else begin
          lo = (ay < by) ? ay : by;
          hi = (ay < by) ? by : ay;
          ok = (ax != ox) && !(p.dir_right && ox > ax) && !(!p.dir_right && ox < ax);
          if (ok && !p.ray_vertical) begin
            y = (m * ax + b) / 65536;
            if (y >= lo && y <= hi) begin
              r.hit = 1'b1;
              r.hit_x = ax[15:0];
              r.hit_y = y[15:0];
            end
          end
        end
      end
      pending.push_back(r);
    endfunction

    // Compare one result beat with the oldest expectation
    function void check_result(out_t got);
      out_t exp_r;
      if (pending.size() == 0) begin
        $error("unexpected result beat %p", got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.hit !== exp_r.hit) begin
        $error("hit exp %0d got %0d", exp_r.hit, got.hit); errors++;
      end
      if (got.hit_x !== exp_r.hit_x) begin
        $error("hit_x exp %0d got %0d", exp_r.hit_x, got.hit_x); errors++;
      end
      if (got.hit_y !== exp_r.hit_y) begin
        $error("hit_y exp %0d got %0d", exp_r.hit_y, got.hit_y); errors++;
      end
      if (got.wall_bad !== exp_r.wall_bad) begin
        $error("wall_bad exp %0d got %0d", exp_r.wall_bad, got.wall_bad); errors++;
      end
    endfunction
  endclass

  logic clk, rst_n, in_push, in_full, out_empty, out_pop;
  in_t  in_data;
  out_t out_data;
  crossing_board board;
  bit   hold_off;

  ray_axis_wall_intersect_unit u_top (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("== FAIL ==");
    $finish;
  end

  // Note accepted beats on both sides
  always @(posedge clk) begin
    if (rst_n && in_push && !in_full) board.note_pair(in_data);
    if (rst_n && out_pop && !out_empty) board.check_result(out_data);
  end

  // Receiver stall pattern, with one long hold-off counted here on request
  initial begin
    int mode;
    out_pop = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off) begin
        out_pop <= 1'b0;
        repeat (200) @(posedge clk);
        hold_off = 0;
      end else begin
        mode = int'(($time / 2000) % 3);
        if (mode == 0) out_pop <= 1'b1;
        else if (mode == 1) out_pop <= ($urandom_range(0, 3) != 0);
        else out_pop <= ($urandom_range(0, 2) == 0);
      end
      @(posedge clk);
    end
  end

  // Present one beat and hold it until accepted
  task automatic send_pair(in_t p);
    in_push <= 1'b1;
    in_data <= p;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  task automatic idle_gap(int n);
    in_push <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic signed [15:0] coord();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 400)) - 200);
    endcase
  endfunction

  // Mostly well-formed wall (one in ten is malformed), mostly near the origin so hits come often
  function automatic in_t random_pair();
    in_t p;
    longint yi;
    p.origin_x = coord();
    p.origin_y = coord();
    p.dir_right = 1'($urandom);
    p.dir_up = 1'($urandom);
    p.ray_vertical = ($urandom_range(0, 7) == 0);
    case ($urandom_range(0, 4))
      0: p.ray_slope = $urandom;
      1: p.ray_slope = '0;
      2: p.ray_slope = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: p.ray_slope = $signed($urandom_range(0, 1 << 19)) - (1 << 18);
    endcase
    if ($urandom_range(0, 3) == 0) p.ray_intercept = 40'({$urandom, $urandom});
    else begin
      yi = longint'(p.origin_y) * 65536 - longint'(p.ray_slope) * p.origin_x;
      p.ray_intercept = yi[39:0];
    end
    p.wall_vertical = 1'($urandom);
    p.wall_ax = coord();
    p.wall_ay = coord();
    p.wall_bx = p.wall_vertical ? p.wall_ax : coord();
    p.wall_by = p.wall_vertical ? coord() : p.wall_ay;
    if ($urandom_range(0, 9) == 0) begin
      p.wall_bx = coord();
      p.wall_by = coord();
    end
    return p;
  endfunction

  initial begin
    in_t p;
    int burst;
    bit hold_done;
    board = new();
    rst_n = 1'b0;
    in_push = 1'b0;
    in_data = '0;
    hold_off = 0;
    hold_done = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: vertical ray on horizontal wall
    p = '0; p.ray_vertical = 1'b1; p.dir_up = 1'b1; p.wall_ax = -16'sd10; p.wall_bx = 16'sd10;
    p.wall_ay = 16'sd5; p.wall_by = 16'sd5; send_pair(p);
    // horizontal wall behind an upward ray
    p.wall_ay = -16'sd5; p.wall_by = -16'sd5; send_pair(p);
    // horizontal wall through the origin
    p.wall_ay = '0; p.wall_by = '0; send_pair(p);
    // vertical ray, vertical wall: parallel
    p.wall_vertical = 1'b1; p.wall_ax = 16'sd5; p.wall_bx = 16'sd5;
    p.wall_ay = -16'sd9; p.wall_by = 16'sd9;
    send_pair(p);
    // sloped ray on vertical wall, both directions
    p.ray_vertical = 1'b0; p.ray_slope = 32'sh00010000; p.dir_right = 1'b1; send_pair(p);
    p.dir_right = 1'b0; send_pair(p);
    p.wall_ax = -16'sd5; p.wall_bx = -16'sd5; send_pair(p);
    // vertical wall through the origin
    p.wall_ax = '0; p.wall_bx = '0; send_pair(p);
    // zero slope on horizontal wall
    p.wall_vertical = 1'b0; p.ray_slope = '0; p.wall_ay = 16'sd3; p.wall_by = 16'sd3;
    p.wall_ax = 16'sd9; p.wall_bx = -16'sd9; send_pair(p);
    // negative slope, reversed endpoints, hit downward
    p.ray_slope = -32'sh00020000; p.dir_up = 1'b0; p.wall_ay = -16'sd4; p.wall_by = -16'sd4;
    send_pair(p);
    // bad walls of each orientation
    p.wall_by = 16'sd7; send_pair(p);
    p.wall_vertical = 1'b1; p.wall_bx = 16'sd1; send_pair(p);
    // field extremes
    p = '1; send_pair(p);
    p = '0; p.origin_x = 16'sh8000; p.origin_y = 16'sh8000; p.ray_slope = 32'sh80000000;
    p.ray_intercept = 40'sh8000000000; p.wall_ax = 16'sh7fff; p.wall_bx = 16'sh7fff;
    p.wall_ay = 16'sh8000; p.wall_by = 16'sh7fff; p.wall_vertical = 1'b1; p.dir_right = 1'b1;
    send_pair(p);
    p.wall_vertical = 1'b0; p.wall_ay = 16'sh7fff; p.wall_ax = 16'sh8000; p.dir_up = 1'b1;
    p.ray_slope = 32'sh7fffffff; p.ray_intercept = 40'sh7fffffffff; send_pair(p);
    p.ray_slope = 32'sd1; send_pair(p);

    // Random bursts; one long receiver hold-off while the sender keeps offering
    for (int i = 0; i < 1340; ) begin
      burst = $urandom_range(1, 40);
      if (i >= 300 && !hold_done) begin
        hold_off = 1;
        hold_done = 1;
      end
      for (int k = 0; k < burst && i < 1340; k++, i++) send_pair(random_pair());
      if (!hold_off && $urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
    end
    in_push <= 1'b0;

    // Drain, then let the pipeline settle
    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (board.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
